FILE: design/fbte_pkg.sv
// fbte_pkg: shared widths, entry struct and the constant twiddle tables
// for the fft butterfly table entry block; no dependencies
package fbte_pkg;

  localparam int LOG2_SIZE_MAX = 10;
  localparam int LOG2_W        = 4;
  localparam int PASS_W        = 4;
  localparam int IDX_W         = 10;
  localparam int TW_W          = 16;
  localparam int MAG_W         = TW_W - 1;
  localparam int TAB_AW        = 8;
  localparam int TAB_DEPTH     = 1 << TAB_AW;
  localparam int TAB_HALF      = TAB_DEPTH / 2;
  localparam int SERIES_TERMS  = 12;
  localparam int TW_SHIFT      = 63 - TW_W;

  localparam logic [LOG2_W-1:0] LOG2_SIZE_RESET = 4'd8;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;
  localparam logic [63:0] HALF_PI_Q62 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] MAG_MAX     = (64'd1 << MAG_W) - 64'd1;

  // quadrant codes of the 10-bit angle
  localparam logic [1:0] QUAD_0 = 2'd0;
  localparam logic [1:0] QUAD_1 = 2'd1;
  localparam logic [1:0] QUAD_2 = 2'd2;
  localparam logic [1:0] QUAD_3 = 2'd3;

  typedef logic [TAB_DEPTH-1:0][MAG_W-1:0] tab_t;

  typedef struct packed {
    logic [IDX_W-1:0]       first_index;
    logic [IDX_W-1:0]       second_index;
    logic signed [TW_W-1:0] twiddle_real;
    logic signed [TW_W-1:0] twiddle_imag;
    logic                   bad_request;
  } entry_t;

  // low 64 bits of (a*b) >> s
  function automatic logic [63:0] mul_shr(logic [63:0] a, logic [63:0] b,
                                          int unsigned s);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    p = p >> s;
    mul_shr = p[63:0];
  endfunction

  // restoring long division for the table build, small divisors only
  function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
    logic [63:0] q, rem;
    q   = '0;
    rem = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[62:0], num[i]};
      if (rem >= den) begin
        rem  = rem - den;
        q[i] = 1'b1;
      end
    end
    udiv64 = q;
  endfunction

  // q62 taylor series, returns {sin, cos} of x in [0, pi/4]
  function automatic logic [127:0] sincos_q62(logic [63:0] x);
    logic [63:0] x2, ts, tc, s, c, dv_s, dv_c;
    x2 = mul_shr(x, x, 62);
    ts = x;
    tc = ONE_Q62;
    s  = x;
    c  = ONE_Q62;
    for (int n = 1; n <= SERIES_TERMS; n++) begin
      dv_s = 64'((2 * n) * (2 * n + 1));
      dv_c = 64'((2 * n - 1) * (2 * n));
      ts = udiv64(mul_shr(ts, x2, 62), dv_s);
      tc = udiv64(mul_shr(tc, x2, 62), dv_c);
      if ((n & 1) == 1) begin
        s = s - ts;
        c = c - tc;
      end else begin
        s = s + ts;
        c = c + tc;
      end
    end
    sincos_q62 = {s, c};
  endfunction

  // q62 magnitude rounded to nearest q1.15, +1.0 saturated
  function automatic logic [MAG_W-1:0] to_mag(logic [63:0] v);
    logic [63:0] r;
    r = (v + (64'd1 << (TW_SHIFT - 1))) >> TW_SHIFT;
    if (r > MAG_MAX) r = MAG_MAX;
    to_mag = r[MAG_W-1:0];
  endfunction

  // quarter-wave table over 1024 steps of the full circle
  function automatic tab_t build_tab(logic want_cos);
    tab_t        t;
    logic [127:0] sc;
    logic [63:0]  ang, s, c;
    for (int j = 0; j < TAB_DEPTH; j++) begin
      ang = 64'(j) << 22;
      if (j <= TAB_HALF) begin
        sc = sincos_q62(mul_shr(ang, HALF_PI_Q62, 30));
        s  = sc[127:64];
        c  = sc[63:0];
      end else begin
        sc = sincos_q62(mul_shr((64'd1 << 30) - ang, HALF_PI_Q62, 30));
        s  = sc[63:0];
        c  = sc[127:64];
      end
      t[j] = to_mag(want_cos ? c : s);
    end
    build_tab = t;
  endfunction

  localparam tab_t SIN_TAB = build_tab(1'b0);
  localparam tab_t COS_TAB = build_tab(1'b1);

endpackage

FILE: design/fft_butterfly_table_entry.sv
// fft_butterfly_table_entry: top level, input and result registers around
// the entry logic; depends on fbte_pkg and fbte_entry
//
// Usage: a request beat (pass_number, position) enters on in_valid/in_ready
// and one result beat (first_index, second_index, twiddle_real,
// twiddle_imag, bad_request) leaves on out_valid/out_ready for each request.
// log2_size is written through cfg_write/cfg_data while no request is in
// flight; it takes effect for the next request.
// Pipeline: two register stages, the input register and then the result
// register after the address logic and twiddle rom read; out_valid rises
// once an accepted request has passed through both.
// Throughput: one request per cycle while out_ready stays high; the path is
// one rom read plus narrow shifts and masks between the two registers.
// Stall: when out_ready is low the result register holds; the input
// register still takes one more beat, and in_ready falls only once both
// registers are full. No beat is dropped or repeated.
// Reset: rst (synchronous, active high) empties both registers and sets
// log2_size to 8 (256 points). No clearing pass is needed.
module fft_butterfly_table_entry (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [fbte_pkg::LOG2_W-1:0]           cfg_data,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [fbte_pkg::PASS_W-1:0]           pass_number,
  input  logic [fbte_pkg::IDX_W-1:0]            position,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [fbte_pkg::IDX_W-1:0]            first_index,
  output logic [fbte_pkg::IDX_W-1:0]            second_index,
  output logic signed [fbte_pkg::TW_W-1:0]      twiddle_real,
  output logic signed [fbte_pkg::TW_W-1:0]      twiddle_imag,
  output logic                                  bad_request
);
  import fbte_pkg::*;

  logic [LOG2_W-1:0] log2_size;
  logic              s1_valid;
  logic [PASS_W-1:0] s1_pass;
  logic [IDX_W-1:0]  s1_pos;
  entry_t            entry;
  entry_t            result;
  logic              out_adv;

  // handshake: result register moves when empty or taken
  assign out_adv  = !out_valid || out_ready;
  assign in_ready = !s1_valid || out_adv;

  fbte_entry u_entry (
    .log2_size   (log2_size),
    .pass_number (s1_pass),
    .position    (s1_pos),
    .entry       (entry)
  );

  // control state and size register
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size <= LOG2_SIZE_RESET;
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) log2_size <= cfg_data;
      if (in_ready) s1_valid <= in_valid;
      if (out_adv) out_valid <= s1_valid;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_pass <= pass_number;
      s1_pos  <= position;
    end
    if (out_adv && s1_valid) result <= entry;
  end

  assign first_index  = result.first_index;
  assign second_index = result.second_index;
  assign twiddle_real = result.twiddle_real;
  assign twiddle_imag = result.twiddle_imag;
  assign bad_request  = result.bad_request;

  // a bad request carries all-zero fields
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_request |-> first_index == '0 && second_index == '0 &&
      twiddle_real == '0 && twiddle_imag == '0)
    else $error("bad request with nonzero fields");

  // the two legs of a butterfly never coincide
  a_legs_differ: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_request |-> first_index != second_index)
    else $error("butterfly legs equal");

  // an accepted beat always lands in the input register
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> s1_valid)
    else $error("accepted beat lost");

  // both registers full and stalled means no new beat is taken
  a_full_backpressure: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_valid && !out_ready |-> !in_ready)
    else $error("beat accepted while full");

  // a waiting input beat reaches the result register when it is free
  a_forward: assert property (@(posedge clk) disable iff (rst)
    s1_valid && out_adv |=> out_valid)
    else $error("pending beat not forwarded");

endmodule

FILE: design/fbte_entry.sv
// fbte_entry: combinational table entry for one request
// depends on fbte_pkg (widths, entry_t, twiddle tables)
module fbte_entry (
  input  logic [fbte_pkg::LOG2_W-1:0] log2_size,
  input  logic [fbte_pkg::PASS_W-1:0] pass_number,
  input  logic [fbte_pkg::IDX_W-1:0]  position,
  output fbte_pkg::entry_t            entry
);
  import fbte_pkg::*;

  logic [LOG2_W-1:0]      lsz;
  logic                   bad;
  logic [IDX_W-1:0]       pbit, i1, i2, k, ang, r1, r2;
  logic [LOG2_W-1:0]      ang_sh, rev_sh;
  logic [TAB_AW-1:0]      tidx;
  logic signed [TW_W-1:0] sm, cm, re, im;
  logic                   lower_leg;

  // size saturated into 1 .. LOG2_SIZE_MAX
  always_comb begin
    if (log2_size == '0) lsz = LOG2_W'(1);
    else if (log2_size > LOG2_W'(LOG2_SIZE_MAX)) lsz = LOG2_W'(LOG2_SIZE_MAX);
    else lsz = log2_size;
  end

  // butterfly legs and range check
  always_comb begin
    bad       = (pass_number >= lsz) || ((position >> lsz) != '0);
    pbit      = IDX_W'(1) << pass_number;
    i1        = position & ~pbit;
    i2        = position | pbit;
    k         = position & (pbit - IDX_W'(1));
    lower_leg = |(position & pbit);
  end

  // angle in 1024ths of the circle: k << (9 - pass), independent of size
  always_comb begin
    ang_sh = LOG2_W'(LOG2_SIZE_MAX - 1) - pass_number;
    ang    = k << ang_sh;
    tidx   = ang[TAB_AW-1:0];
    sm     = TW_W'({1'b0, SIN_TAB[tidx]});
    cm     = TW_W'({1'b0, COS_TAB[tidx]});
  end

  // quadrant fold and lower-leg negation
  always_comb begin
    unique case (ang[IDX_W-1:TAB_AW])
      QUAD_0: begin im = sm;  re = cm;  end
      QUAD_1: begin im = cm;  re = -sm; end
      QUAD_2: begin im = -sm; re = -cm; end
      QUAD_3: begin im = -cm; re = sm;  end
      default: begin im = sm; re = cm; end
    endcase
    if (lower_leg) begin
      re = -re;
      im = -im;
    end
  end

  // bit reversal over lsz bits for the first pass
  always_comb begin
    for (int b = 0; b < IDX_W; b++) begin
      r1[b] = i1[IDX_W-1-b];
      r2[b] = i2[IDX_W-1-b];
    end
    rev_sh = LOG2_W'(LOG2_SIZE_MAX) - lsz;
    r1     = r1 >> rev_sh;
    r2     = r2 >> rev_sh;
  end

  // assemble entry, all zero on a bad request
  always_comb begin
    if (bad) begin
      entry             = '0;
      entry.bad_request = 1'b1;
    end else begin
      entry.first_index  = (pass_number == '0) ? r1 : i1;
      entry.second_index = (pass_number == '0) ? r2 : i2;
      entry.twiddle_real = re;
      entry.twiddle_imag = im;
      entry.bad_request  = 1'b0;
    end
  end

endmodule
